// ===== rtl/csd_pkg.sv =====
// shared types and constants for the can signal decoder
// no dependencies; imported by every module of the block
package csd_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int FIELD_MAX     = 32;
    localparam int LEN_W         = 6;
    localparam int POS_W         = 6;
    localparam int APB_ADDR_W    = 6;
    localparam int APB_DATA_W    = 64;
    localparam int FACTOR_W      = 32;
    localparam int OFFSET_W      = 48;
    localparam int FRAC_W        = 16;
    localparam int RAW_W         = FIELD_MAX + 1;
    localparam int PROD_W        = RAW_W + FACTOR_W;
    localparam int SUM_W         = PROD_W + 1;
    localparam int PHYS_W        = 32;

    localparam logic [LEN_W-1:0]    RST_FIELD_LENGTH = 6'd8;
    localparam logic [FACTOR_W-1:0] RST_SCALE_FACTOR = 32'h0001_0000;

    typedef enum logic [2:0] {
        REG_START_POSITION = 3'd0,
        REG_FIELD_LENGTH   = 3'd1,
        REG_ORDER_INTEL    = 3'd2,
        REG_SIGNED_FIELD   = 3'd3,
        REG_SCALE_FACTOR   = 3'd4,
        REG_SCALE_OFFSET   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0]    start_position;
        logic [LEN_W-1:0]    field_length;
        logic                order_intel;
        logic                signed_field;
        logic [FACTOR_W-1:0] scale_factor;
        logic [OFFSET_W-1:0] scale_offset;
    } cfg_t;

endpackage

// ===== rtl/csd_regs.sv =====
// apb configuration registers of the can signal decoder
// depends on csd_pkg
module csd_regs
    import csd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_START_POSITION: cfg_next.start_position = pwdata[POS_W-1:0];
                REG_FIELD_LENGTH:   cfg_next.field_length   = pwdata[LEN_W-1:0];
                REG_ORDER_INTEL:    cfg_next.order_intel    = pwdata[0];
                REG_SIGNED_FIELD:   cfg_next.signed_field   = pwdata[0];
                REG_SCALE_FACTOR:   cfg_next.scale_factor   = pwdata[FACTOR_W-1:0];
                REG_SCALE_OFFSET:   cfg_next.scale_offset   = pwdata[OFFSET_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_position <= '0;
            cfg_reg.field_length   <= RST_FIELD_LENGTH;
            cfg_reg.order_intel    <= 1'b0;
            cfg_reg.signed_field   <= 1'b0;
            cfg_reg.scale_factor   <= RST_SCALE_FACTOR;
            cfg_reg.scale_offset   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_START_POSITION: prdata = APB_DATA_W'(cfg_reg.start_position);
            REG_FIELD_LENGTH:   prdata = APB_DATA_W'(cfg_reg.field_length);
            REG_ORDER_INTEL:    prdata = APB_DATA_W'(cfg_reg.order_intel);
            REG_SIGNED_FIELD:   prdata = APB_DATA_W'(cfg_reg.signed_field);
            REG_SCALE_FACTOR:   prdata = APB_DATA_W'(cfg_reg.scale_factor);
            REG_SCALE_OFFSET:   prdata = APB_DATA_W'(cfg_reg.scale_offset);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== rtl/csd_extract.sv =====
// field extraction stage: intel / motorola bit select, length mask, sign extension
// depends on csd_pkg
module csd_extract
    import csd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  logic [PAYLOAD_W-1:0]    payload,
    input  cfg_t                    cfg,
    output logic                    valid_out,
    output logic [FIELD_MAX-1:0]    pattern,
    output logic signed [RAW_W-1:0] raw
);

    localparam int WIN_W = PAYLOAD_W + FIELD_MAX;
    localparam int SH_W  = $clog2(WIN_W + 1);

    logic                    valid_reg;
    logic [FIELD_MAX-1:0]    pattern_reg;
    logic [FIELD_MAX-1:0]    pattern_next;
    logic signed [RAW_W-1:0] raw_reg;
    logic signed [RAW_W-1:0] raw_next;

    logic [LEN_W-1:0]     len_c;
    logic [FIELD_MAX:0]   mask_w;
    logic [FIELD_MAX-1:0] mask;
    logic [PAYLOAD_W-1:0] intel_win;
    logic [PAYLOAD_W-1:0] swapped;
    logic [WIN_W-1:0]     moto_win;
    logic [POS_W-1:0]     net;
    logic [SH_W-1:0]      moto_sh;
    logic [FIELD_MAX-1:0] field;
    logic [4:0]           msb_idx;

    always_comb
    begin
        len_c  = (cfg.field_length > LEN_W'(FIELD_MAX)) ? LEN_W'(FIELD_MAX) : cfg.field_length;
        mask_w = ((FIELD_MAX+1)'(1) << len_c) - (FIELD_MAX+1)'(1);
        mask   = mask_w[FIELD_MAX-1:0];

        // intel: lsb at start, bits past the payload shift in as zero
        intel_win = payload >> cfg.start_position;

        // motorola: byte-swapped payload is the network order read msb first
        for (int b = 0; b < PAYLOAD_BYTES; b++)
        begin
            swapped[8*b +: 8] = payload[8*(PAYLOAD_BYTES-1-b) +: 8];
        end
        moto_win = {swapped, FIELD_MAX'(0)};
        net      = {cfg.start_position[5:3], ~cfg.start_position[2:0]};
        moto_sh  = SH_W'(WIN_W) - SH_W'(net) - SH_W'(len_c);

        if (cfg.order_intel)
            field = intel_win[FIELD_MAX-1:0] & mask;
        else
            field = moto_win[moto_sh +: FIELD_MAX] & mask;

        msb_idx      = 5'(len_c - LEN_W'(1));
        pattern_next = field;
        if (cfg.signed_field && (len_c != '0) && (len_c < LEN_W'(FIELD_MAX)) && field[msb_idx])
            pattern_next = field | ~mask;

        raw_next = cfg.signed_field ? $signed({pattern_next[FIELD_MAX-1], pattern_next})
                                    : $signed({1'b0, pattern_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pattern_reg <= pattern_next;
            raw_reg     <= raw_next;
        end
    end

    assign valid_out = valid_reg;
    assign pattern   = pattern_reg;
    assign raw       = raw_reg;

endmodule

// ===== rtl/csd_scale.sv =====
// scaling pipeline: multiply by factor, add offset, round half away, saturate
// depends on csd_pkg; last stage is the output register
module csd_scale
    import csd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  logic [FIELD_MAX-1:0]    pattern_in,
    input  logic signed [RAW_W-1:0] raw,
    input  cfg_t                    cfg,
    output logic                    valid_out,
    output logic [FIELD_MAX-1:0]    pattern_out,
    output logic [PHYS_W-1:0]       phys,
    output logic                    sat
);

    localparam int Q_W = SUM_W - FRAC_W;
    localparam logic signed [Q_W-1:0] Q_MAX = {{(Q_W-PHYS_W+1){1'b0}}, {(PHYS_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {{(Q_W-PHYS_W+1){1'b1}}, {(PHYS_W-1){1'b0}}};

    logic                     mul_valid_reg;
    logic [FIELD_MAX-1:0]     mul_pat_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    logic                     add_valid_reg;
    logic [FIELD_MAX-1:0]     add_pat_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    logic                     out_valid_reg;
    logic [FIELD_MAX-1:0]     out_pat_reg;
    logic [PHYS_W-1:0]        phys_reg;
    logic [PHYS_W-1:0]        phys_next;
    logic                     sat_reg;
    logic                     sat_next;

    logic signed [SUM_W-1:0]  rnd;
    logic signed [Q_W-1:0]    q;

    assign prod_next = raw * $signed(cfg.scale_factor);
    assign sum_next  = SUM_W'(prod_reg) + SUM_W'($signed(cfg.scale_offset));

    always_comb
    begin
        // negative sums round down by one less so ties move away from zero
        rnd = sum_reg + (sum_reg[SUM_W-1] ? SUM_W'(16'h7FFF) : SUM_W'(16'h8000));
        q   = Q_W'(rnd >>> FRAC_W);
        if (q > Q_MAX)
        begin
            phys_next = Q_MAX[PHYS_W-1:0];
            sat_next  = 1'b1;
        end
        else if (q < Q_MIN)
        begin
            phys_next = Q_MIN[PHYS_W-1:0];
            sat_next  = 1'b1;
        end
        else
        begin
            phys_next = q[PHYS_W-1:0];
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= valid_in;
            add_valid_reg <= mul_valid_reg;
            out_valid_reg <= add_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_pat_reg <= pattern_in;
            prod_reg    <= prod_next;
            add_pat_reg <= mul_pat_reg;
            sum_reg     <= sum_next;
            out_pat_reg <= add_pat_reg;
            phys_reg    <= phys_next;
            sat_reg     <= sat_next;
        end
    end

    assign valid_out   = out_valid_reg;
    assign pattern_out = out_pat_reg;
    assign phys        = phys_reg;
    assign sat         = sat_reg;

endmodule

// ===== rtl/can_signal_decode_core.sv =====
// can signal decoder top level: input register, extraction, scaling, apb registers
// depends on csd_pkg, csd_regs, csd_extract, csd_scale
//
// Decodes one signal from each 8-byte CAN payload beat: the field is taken at
// the configured start bit in Intel or Motorola order, sign-extended if asked,
// then scaled as raw * factor (Q16.16) + offset (Q32.16), rounded half away
// from zero and clipped to signed 32 bits. One beat is taken every cycle unless
// a result waits on m_tready; each result passes in order through the five
// register stages (input register, extraction, multiplier, offset adder,
// round/saturate output register). The whole pipeline holds while a result
// waits on m_tready. Configuration is to be written only while no beats are
// in flight.
module can_signal_decode_core
    import csd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PAYLOAD_W-1:0]  s_tdata,   // [63:0] payload
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // [31:0] raw_pattern, [63:32] physical_value
    output logic                  m_tuser,   // [0] saturated
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t                    cfg;
    logic                    en;
    logic                    in_valid_reg;
    logic [PAYLOAD_W-1:0]    payload_reg;
    logic                    ext_valid;
    logic [FIELD_MAX-1:0]    ext_pattern;
    logic signed [RAW_W-1:0] ext_raw;
    logic [FIELD_MAX-1:0]    out_pattern;
    logic [PHYS_W-1:0]       out_phys;
    logic                    out_sat;

    // advance everything unless the output beat is held
    assign en       = ~(m_tvalid & ~m_tready);
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (en)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            payload_reg <= s_tdata;
    end

    csd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csd_extract u_extract (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid_reg),
        .payload   (payload_reg),
        .cfg       (cfg),
        .valid_out (ext_valid),
        .pattern   (ext_pattern),
        .raw       (ext_raw)
    );

    csd_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .valid_in    (ext_valid),
        .pattern_in  (ext_pattern),
        .raw         (ext_raw),
        .cfg         (cfg),
        .valid_out   (m_tvalid),
        .pattern_out (out_pattern),
        .phys        (out_phys),
        .sat         (out_sat)
    );

    assign m_tdata = {out_phys, out_pattern};
    assign m_tuser = out_sat;

    a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[63:32] == 32'h7FFF_FFFF) ||
                                (m_tdata[63:32] == 32'h8000_0000))
        else $error("saturated flag without a rail value");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output beat is held");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("output beat dropped without handshake");

endmodule

// ===== tb/tb_can_signal_decode_core.sv =====
// self-checking testbench for can_signal_decode_core: stream beats in, decoded signal out
// depends on csd_pkg and the rtl of the block; a local predictor computes every result
`timescale 1ns / 1ps

module tb_can_signal_decode_core;

    import csd_pkg::*;

    localparam int      MAX_IDLE        = 17;
    localparam int      REG_STRIDE      = 8;
    localparam int      UNMAPPED_IDX_LO = 6;
    localparam int      UNMAPPED_IDX_HI = 7;
    localparam int      RAND_PHASES     = 8;
    localparam int      PHASE_ITEMS     = 240;
    localparam int      HOLD_AT_FIRST   = 700;
    localparam int      HOLD_AT_SECOND  = 1400;
    localparam int      LONG_HOLD       = 400;
    localparam int      PIPE_SETTLE     = 8;
    localparam int      DRAIN_LIMIT     = 4000;
    localparam longint  TIMEOUT_NS      = 64'd4_000_000;
    localparam longint  PROD_CLAMP      = 64'sh4000_0000_0000_0000;
    localparam longint  ROUND_HALF      = 64'sd32768;
    localparam longint  PHYS_MAX        = 64'sd2147483647;
    localparam longint  PHYS_MIN        = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] raw_pattern;
        logic [31:0] physical_value;
        logic        saturated;
    } decoded_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PAYLOAD_W-1:0]  s_tdata  = '0;   // [63:0] payload
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;         // [31:0] raw_pattern, [63:32] physical_value
    logic                  m_tuser;         // [0] saturated
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cfg_t        shadow_cfg;
    logic [63:0] pending_payloads[$];
    decoded_t    expected_decodes[$];
    int          payloads_queued   = 0;
    int          payloads_accepted = 0;
    int          results_seen      = 0;
    int          saturated_seen    = 0;
    int          settings_applied  = 0;
    int          error_count       = 0;
    int unsigned send_wait         = 0;
    int unsigned recv_wait         = 0;
    int unsigned recv_hold         = 0;
    bit          sender_burst      = 1'b0;
    bit          receiver_burst    = 1'b0;

    can_signal_decode_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // field extraction, sign extension and fixed-point scaling of one payload
    function automatic decoded_t decode_signal(logic [63:0] payload, cfg_t c);
        int unsigned len;
        int unsigned net;
        int unsigned n;
        int unsigned pos;
        int unsigned i;
        logic [31:0] pat;
        longint      raw_val;
        longint      fac;
        longint      off;
        longint      prod;
        longint      sum;
        longint      q;
        decoded_t    d;
        len = (c.field_length > FIELD_MAX) ? FIELD_MAX : c.field_length;
        pat = '0;
        // motorola start bit is a sawtooth index, walk network order from it
        net = {c.start_position[5:3], 3'b000} + (7 - c.start_position[2:0]);
        for (i = 0; i < len; i++)
        begin
            if (c.order_intel)
                pos = c.start_position + len - 1 - i;
            else
            begin
                n   = net + i;
                pos = (n & ~32'd7) + (7 - (n & 32'd7));
            end
            pat = {pat[30:0], (pos < PAYLOAD_W) && payload[pos[5:0]]};
        end
        if (c.signed_field)
        begin
            if (len > 0 && len < FIELD_MAX && pat[len-1])
                pat = pat | (32'hFFFF_FFFF << len);
            raw_val = $signed(pat);
        end
        else
            raw_val = {32'd0, pat};
        fac  = $signed(c.scale_factor);
        off  = $signed(c.scale_offset);
        prod = raw_val * fac;
        if (prod > PROD_CLAMP)
            prod = PROD_CLAMP;
        if (prod < -PROD_CLAMP)
            prod = -PROD_CLAMP;
        sum = prod + off;
        if (sum >= 0)
            q = (sum + ROUND_HALF) >>> FRAC_W;
        else
            q = -((-sum + ROUND_HALF) >>> FRAC_W);
        d.saturated = 1'b0;
        if (q > PHYS_MAX)
        begin
            q = PHYS_MAX;
            d.saturated = 1'b1;
        end
        if (q < PHYS_MIN)
        begin
            q = PHYS_MIN;
            d.saturated = 1'b1;
        end
        d.raw_pattern    = pat;
        d.physical_value = q[31:0];
        return d;
    endfunction

    // random bits above the register width, which the block must drop
    function automatic logic [63:0] with_noise(logic [63:0] value, int width);
        logic [63:0] keep;
        keep = (64'd1 << width) - 1;
        return ({$urandom, $urandom} & ~keep) | (value & keep);
    endfunction

    task automatic cfg_write(input int idx, input logic [63:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * REG_STRIDE);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_START_POSITION: shadow_cfg.start_position = data[POS_W-1:0];
            REG_FIELD_LENGTH:   shadow_cfg.field_length   = data[LEN_W-1:0];
            REG_ORDER_INTEL:    shadow_cfg.order_intel    = data[0];
            REG_SIGNED_FIELD:   shadow_cfg.signed_field   = data[0];
            REG_SCALE_FACTOR:   shadow_cfg.scale_factor   = data[FACTOR_W-1:0];
            REG_SCALE_OFFSET:   shadow_cfg.scale_offset   = data[OFFSET_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_read(input int idx, output logic [63:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(idx * REG_STRIDE);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_regs();
        logic [63:0] rd;
        logic [63:0] want;
        int          width;
        int          idx;
        for (idx = REG_START_POSITION; idx <= REG_SCALE_OFFSET; idx++)
        begin
            cfg_read(idx, rd);
            case (idx)
                REG_START_POSITION: begin want = 64'(shadow_cfg.start_position); width = POS_W; end
                REG_FIELD_LENGTH:   begin want = 64'(shadow_cfg.field_length);   width = LEN_W; end
                REG_ORDER_INTEL:    begin want = 64'(shadow_cfg.order_intel);    width = 1; end
                REG_SIGNED_FIELD:   begin want = 64'(shadow_cfg.signed_field);   width = 1; end
                REG_SCALE_FACTOR:   begin want = 64'(shadow_cfg.scale_factor);   width = FACTOR_W; end
                default:            begin want = 64'(shadow_cfg.scale_offset);   width = OFFSET_W; end
            endcase
            if ((rd & ((64'd1 << width) - 1)) !== want)
            begin
                $error("register %0d readback expected %h actual %h", idx, want, rd);
                error_count++;
            end
        end
    endtask

    task automatic set_config(input int sp, input int len, input bit intel, input bit sgn,
                              input logic [31:0] fac, input logic [47:0] off);
        cfg_write(REG_START_POSITION, with_noise(64'(sp), POS_W));
        cfg_write(REG_FIELD_LENGTH, with_noise(64'(len), LEN_W));
        cfg_write(REG_ORDER_INTEL, with_noise(64'(intel), 1));
        cfg_write(REG_SIGNED_FIELD, with_noise(64'(sgn), 1));
        cfg_write(REG_SCALE_FACTOR, with_noise(64'(fac), FACTOR_W));
        cfg_write(REG_SCALE_OFFSET, with_noise(64'(off), OFFSET_W));
        settings_applied++;
        verify_regs();
    endtask

    task automatic queue_payload(input logic [63:0] p);
        pending_payloads.push_back(p);
        payloads_queued++;
    endtask

    task automatic wait_drained();
        int guard;
        while (payloads_accepted != payloads_queued)
            @(posedge clk);
        guard = 0;
        while (expected_decodes.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_decodes.size() != 0)
        begin
            $error("%0d decoded results never arrived", expected_decodes.size());
            error_count++;
        end
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // sender: one payload per beat, random gap after each unless in burst mode
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_decodes.push_back(decode_signal(s_tdata, shadow_cfg));
                payloads_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_wait != 0)
                begin
                    send_wait <= send_wait - 1;
                    s_tvalid  <= 1'b0;
                end
                else if (pending_payloads.size() != 0)
                begin
                    s_tvalid  <= 1'b1;
                    s_tdata   <= pending_payloads.pop_front();
                    send_wait <= sender_burst ? 0 : $urandom_range(0, MAX_IDLE);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks each result beat, then drops m_tready for a random stall, none in burst mode
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_decodes.size() == 0)
                begin
                    $error("result beat with nothing expected: m_tdata %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    decoded_t want;
                    want = expected_decodes.pop_front();
                    if (m_tdata[31:0] !== want.raw_pattern)
                    begin
                        $error("raw_pattern expected %h actual %h",
                               want.raw_pattern, m_tdata[31:0]);
                        error_count++;
                    end
                    if (m_tdata[63:32] !== want.physical_value)
                    begin
                        $error("physical_value expected %0d actual %0d",
                               $signed(want.physical_value), $signed(m_tdata[63:32]));
                        error_count++;
                    end
                    if (m_tuser !== want.saturated)
                    begin
                        $error("saturated expected %b actual %b", want.saturated, m_tuser);
                        error_count++;
                    end
                    if (want.saturated)
                        saturated_seen++;
                end
                results_seen++;
                // two long back-pressure stretches so the pipeline fills and stalls input
                if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND)
                    recv_hold = LONG_HOLD;
                else
                    recv_hold = receiver_burst ? 0 : $urandom_range(0, MAX_IDLE);
                recv_wait <= recv_hold;
                m_tready  <= (recv_hold == 0);
            end
            else if (recv_wait > 1)
            begin
                recv_wait <= recv_wait - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                recv_wait <= 0;
                m_tready  <= 1'b1;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int          ph;
        int          k;
        int          sp;
        int          len;
        bit          intel;
        bit          sgn;
        logic [31:0] fac;
        logic [47:0] off;
        logic [31:0] r;
        logic [63:0] p;

        shadow_cfg                = '0;
        shadow_cfg.field_length   = RST_FIELD_LENGTH;
        shadow_cfg.scale_factor   = RST_SCALE_FACTOR;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: motorola, start 0, 8 bits, unity factor
        settings_applied++;
        verify_regs();
        queue_payload(64'h0);
        queue_payload('1);
        queue_payload(64'h0123_4567_89AB_CDEF);
        wait_drained();

        // intel field at the top bit, mostly past the end of the payload
        set_config(63, 16, 1'b1, 1'b0, 32'h0001_0000, 48'h0);
        queue_payload('1);
        queue_payload(64'h7FFF_FFFF_FFFF_FFFF);
        wait_drained();

        // motorola field running off the last byte
        set_config(60, 32, 1'b0, 1'b0, 32'h0001_0000, 48'h0);
        queue_payload('1);
        wait_drained();

        // full 32-bit signed motorola field
        set_config(7, 32, 1'b0, 1'b1, 32'h0001_0000, 48'h0);
        queue_payload('1);
        queue_payload(64'h0000_0000_0000_0080);
        wait_drained();

        // zero length: offset of -2.5 rounds away from zero
        set_config(0, 0, 1'b1, 1'b1, 32'h0001_0000, 48'hFFFF_FFFD_8000);
        queue_payload('1);
        wait_drained();

        // length above 32 and largest factor and offset: positive clip
        set_config(32, 63, 1'b1, 1'b0, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
        queue_payload('1);
        queue_payload(64'h0);
        wait_drained();

        // smallest factor and offset on a signed motorola field
        set_config(20, 12, 1'b0, 1'b1, 32'h8000_0000, 48'h8000_0000_0000);
        queue_payload('1);
        queue_payload(64'h0000_0000_0080_0000);
        queue_payload(64'h5A5A_A5A5_3C3C_C3C3);
        wait_drained();

        // large unsigned raw times most negative factor: negative clip
        set_config(0, 32, 1'b1, 1'b0, 32'h8000_0000, 48'h0);
        queue_payload('1);
        queue_payload(64'h1);
        wait_drained();

        // half factor exposes rounding of halves either way
        set_config(0, 8, 1'b1, 1'b1, 32'h0000_8000, 48'h0);
        cfg_write(UNMAPPED_IDX_LO, {$urandom, $urandom});
        cfg_write(UNMAPPED_IDX_HI, {$urandom, $urandom});
        verify_regs();
        queue_payload(64'h01);
        queue_payload(64'hFF);
        queue_payload(64'h03);
        queue_payload(64'hFD);
        wait_drained();

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            sp = $urandom_range(0, 63);
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(33, 63);
                2:       len = 32;
                default: len = $urandom_range(1, 31);
            endcase
            intel = $urandom_range(0, 1);
            sgn   = $urandom_range(0, 1);
            case ($urandom_range(0, 3))
                0:       fac = $urandom;
                1:       fac = 32'h0001_0000;
                default: fac = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            endcase
            r = $urandom;
            case ($urandom_range(0, 2))
                0:       off = 48'({$urandom, $urandom});
                1:       off = 48'h0;
                default: off = {{16{r[31]}}, r};
            endcase
            set_config(sp, len, intel, sgn, fac, off);
            sender_burst   = ($urandom_range(0, 3) == 0);
            receiver_burst = ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                case ($urandom_range(0, 15))
                    0:       p = '0;
                    1:       p = '1;
                    2:       p = 64'd1 << $urandom_range(0, 63);
                    default: p = {$urandom, $urandom};
                endcase
                queue_payload(p);
            end
            wait_drained();
        end

        $display("decoded %0d payloads under %0d register settings, %0d results clipped",
                 payloads_accepted, settings_applied, saturated_seen);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
